/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------
// Assertion macros
// Shorthand for the concurrent checks used across the project.
// ----------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also applies during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/rtp_pkg.sv */
// ----------------------------------------------------------------------
// Rectangular to polar converter package
// Widths, pipeline sizes, angle table and shared types.
// ----------------------------------------------------------------------
`default_nettype none

package rtp_pkg;

   // Field widths.
   localparam int RE_W    = 32;
   localparam int IM_W    = 32;
   localparam int MAG_W   = 41;
   localparam int PHASE_W = 17;

   localparam int MAG_FRAC_BITS   = 8;
   localparam int PHASE_FRAC_BITS = 16;

   // Magnitude path: exact integer square root of (re^2 + im^2) << 2F.
   localparam int SQ_W       = 2 * RE_W;
   localparam int SUM_W      = SQ_W + 1;
   localparam int RAD_W      = SUM_W + 2 * MAG_FRAC_BITS;
   localparam int SQRT_STEPS = (RAD_W + 1) / 2;
   localparam int RAD_PAD_W  = 2 * SQRT_STEPS;
   localparam int ROOT_W     = SQRT_STEPS;
   localparam int REM_W      = ROOT_W + 2;

   // Phase path: vectoring rotations on operands normalized to bit NORM_TOP.
   localparam int CORDIC_STEPS = 32;
   localparam int NORM_TOP     = 59;
   localparam int SHIFT_W      = $clog2(NORM_TOP + 1);
   localparam int LZC_W        = $clog2(RE_W);
   localparam int CW           = 63;
   localparam int ANG_FRAC     = 32;
   localparam int ZW           = 35;
   localparam int PHASE_DROP   = ANG_FRAC - PHASE_FRAC_BITS;

   localparam logic [ZW-1:0] HALF_PI_Q32 = ZW'(64'd6746518852);
   localparam logic [ZW-1:0] PHASE_ROUND = ZW'(1) << (PHASE_DROP - 1);
   localparam logic [PHASE_W-1:0] PHASE_HALF_PI =
      PHASE_W'((HALF_PI_Q32 + PHASE_ROUND) >> PHASE_DROP);

   // Result buffer in front of the output channel.
   localparam int OUT_BUF_DEPTH = 2;
   localparam int BUF_PTR_W     = $clog2(OUT_BUF_DEPTH);
   localparam int BUF_CNT_W     = $clog2(OUT_BUF_DEPTH + 1);

   typedef enum logic [1:0] {
      PC_CORDIC,
      PC_ZERO,
      PC_HALF_PI,
      PC_UNDEF
   } phase_case_type;

   typedef struct packed {
      logic [RAD_PAD_W-1:0] radicand;
      logic [CW-1:0]        x;
      logic [CW-1:0]        y;
      phase_case_type       pcase;
   } front_item_type;

   typedef struct packed {
      logic [MAG_W-1:0]   magnitude;
      logic [PHASE_W-1:0] phase;
      logic               phase_undefined;
   } rsp_item_type;

   // atan(2^-i) scaled by 2^32; past the table it equals 2^(32-i).
   function automatic logic signed [ZW-1:0] cordic_angle(input int step);
      logic signed [ZW-1:0] ang;
      case (step)
         0:  ang = ZW'(64'd3373259426);
         1:  ang = ZW'(64'd1991351318);
         2:  ang = ZW'(64'd1052175346);
         3:  ang = ZW'(64'd534100635);
         4:  ang = ZW'(64'd268086748);
         5:  ang = ZW'(64'd134174063);
         6:  ang = ZW'(64'd67103403);
         7:  ang = ZW'(64'd33553749);
         8:  ang = ZW'(64'd16777131);
         9:  ang = ZW'(64'd8388597);
         10: ang = ZW'(64'd4194303);
         default: begin
            if (step <= ANG_FRAC) begin
               ang = ZW'(64'd1 << (ANG_FRAC - step));
            end else begin
               ang = '0;
            end
         end
      endcase
      return ang;
   endfunction

endpackage

`default_nettype wire

/* rtl/rtp_if.sv */
// ----------------------------------------------------------------------
// Rectangular to polar converter channels
// Valid/ready channels for the input bins and the polar results.
// ----------------------------------------------------------------------
`default_nettype none

interface rtp_req_if import rtp_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [RE_W-1:0] real_part;
   logic [IM_W-1:0] imag_part;

   modport source (output valid, output real_part, output imag_part, input ready);
   modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

interface rtp_rsp_if import rtp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [MAG_W-1:0]   magnitude;
   logic [PHASE_W-1:0] phase;
   logic               phase_undefined;

   modport source (output valid, output magnitude, output phase,
                   output phase_undefined, input ready);
   modport sink   (input valid, input magnitude, input phase,
                   input phase_undefined, output ready);
endinterface

`default_nettype wire

/* rtl/rect_to_polar_converter.sv */
// ----------------------------------------------------------------------
// Rectangular to polar converter
// Path from the accepting edge to the offered result: input register, two
// more front stages, 41 square root digits, rounding, buffer.
// Throughput: one item per cycle when not stalled; the square root sets the
// stage count. A full result buffer stalls the whole pipeline and the input.
// Reset clears the valid bits and the two-entry result buffer only.
// ----------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rect_to_polar_converter import rtp_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   rtp_req_if.sink   req_bus,
   rtp_rsp_if.source rsp_bus
);

   logic               pipe_en;
   logic               front_valid;
   front_item_type     front_item;
   logic               core_valid;
   logic [MAG_W-1:0]   core_mag;
   logic [PHASE_W-1:0] core_phase;
   logic               core_undef;
   rsp_item_type       core_item;
   logic               head_valid;
   rsp_item_type       head_item;

   // The whole pipeline moves together whenever the buffer has room.
   assign req_bus.ready = pipe_en;

   rtp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_bus.valid),
      .real_part (req_bus.real_part),
      .imag_part (req_bus.imag_part),
      .out_valid (front_valid),
      .out_item  (front_item)
   );

   rtp_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (front_valid),
      .radicand  (front_item.radicand),
      .out_valid (core_valid),
      .magnitude (core_mag)
   );

   rtp_cordic u_cordic (
      .clock           (clock),
      .en              (pipe_en),
      .x               (front_item.x),
      .y               (front_item.y),
      .pcase           (front_item.pcase),
      .phase           (core_phase),
      .phase_undefined (core_undef)
   );

   assign core_item.magnitude       = core_mag;
   assign core_item.phase           = core_phase;
   assign core_item.phase_undefined = core_undef;

   rtp_out_buffer u_out_buffer (
      .clock      (clock),
      .reset      (reset),
      .push_valid (core_valid),
      .push_item  (core_item),
      .push_ready (pipe_en),
      .pop_ready  (rsp_bus.ready),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   assign rsp_bus.valid           = head_valid;
   assign rsp_bus.magnitude       = head_item.magnitude;
   assign rsp_bus.phase           = head_item.phase;
   assign rsp_bus.phase_undefined = head_item.phase_undefined;

   `ASSERT_CLK_RST(a_stall_holds_item, clock, reset, (core_valid && !pipe_en) |=> core_valid, "finished item lost while the buffer was full")
   `ASSERT_CLK_RST(a_undef_is_zero, clock, reset, (rsp_bus.valid && rsp_bus.phase_undefined) |-> ((rsp_bus.magnitude == '0) && (rsp_bus.phase == '0)), "undefined phase with nonzero result")
   `ASSERT_CLK_RST(a_phase_in_range, clock, reset, rsp_bus.valid |-> (rsp_bus.phase <= PHASE_HALF_PI), "phase above pi over two")
   `ASSERT_CLK(a_reset_empties, clock, reset |=> !rsp_bus.valid, "result offered right after reset")

endmodule

`default_nettype wire

/* rtl/rtp_front.sv */
// ----------------------------------------------------------------------
// Front end
// Input register, squares, normalizing shift and case selection.
// ----------------------------------------------------------------------
`default_nettype none

module rtp_front import rtp_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            in_valid,
   input  wire logic [RE_W-1:0] real_part,
   input  wire logic [IM_W-1:0] imag_part,
   output logic                 out_valid,
   output front_item_type       out_item
);

   // Stage 0: input register.
   logic            v0_ff;
   logic [RE_W-1:0] re0_ff;
   logic [IM_W-1:0] im0_ff;

   // Stage 1: squares and shift amount.
   logic               v1_ff;
   logic [RE_W-1:0]    re1_ff;
   logic [IM_W-1:0]    im1_ff;
   logic [SQ_W-1:0]    sq_re1_ff, sq_re1_in;
   logic [SQ_W-1:0]    sq_im1_ff, sq_im1_in;
   logic [SHIFT_W-1:0] shift1_ff, shift1_in;
   phase_case_type     pc1_ff, pc1_in;

   // Stage 2: radicand and normalized operands.
   logic           v2_ff;
   front_item_type item2_ff, item2_in;

   logic [RE_W-1:0]  max_part;
   logic [LZC_W-1:0] top_bit;
   logic [SUM_W-1:0] sq_sum;

   always_comb begin
      max_part = (re0_ff > RE_W'(im0_ff)) ? re0_ff : RE_W'(im0_ff);
      top_bit  = '0;
      for (int b = 0; b < RE_W; b++) begin
         if (max_part[b]) top_bit = LZC_W'(b);
      end
      // Moves the leading one of the larger part up to bit NORM_TOP.
      shift1_in = SHIFT_W'(NORM_TOP) - SHIFT_W'(top_bit);
      sq_re1_in = SQ_W'(re0_ff) * SQ_W'(re0_ff);
      sq_im1_in = SQ_W'(im0_ff) * SQ_W'(im0_ff);
      if (re0_ff == '0 && im0_ff == '0) begin
         pc1_in = PC_UNDEF;
      end else if (re0_ff == '0) begin
         pc1_in = PC_HALF_PI;
      end else if (im0_ff == '0) begin
         pc1_in = PC_ZERO;
      end else begin
         pc1_in = PC_CORDIC;
      end
   end

   always_comb begin
      sq_sum            = SUM_W'(sq_re1_ff) + SUM_W'(sq_im1_ff);
      item2_in.radicand = RAD_PAD_W'(sq_sum) << (2 * MAG_FRAC_BITS);
      item2_in.x        = CW'(SQ_W'(re1_ff) << shift1_ff);
      item2_in.y        = CW'(SQ_W'(im1_ff) << shift1_ff);
      item2_in.pcase    = pc1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         re0_ff    <= real_part;
         im0_ff    <= imag_part;
         re1_ff    <= re0_ff;
         im1_ff    <= im0_ff;
         sq_re1_ff <= sq_re1_in;
         sq_im1_ff <= sq_im1_in;
         shift1_ff <= shift1_in;
         pc1_ff    <= pc1_in;
         item2_ff  <= item2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_item  = item2_ff;

endmodule

`default_nettype wire

/* rtl/rtp_isqrt.sv */
// ----------------------------------------------------------------------
// Magnitude square root
// One root bit per stage from two radicand bits, then round to nearest.
// ----------------------------------------------------------------------
`default_nettype none

module rtp_isqrt import rtp_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic [RAD_PAD_W-1:0] radicand,
   output logic                      out_valid,
   output logic [MAG_W-1:0]          magnitude
);

   logic [RAD_PAD_W-1:0] rad_s  [0:SQRT_STEPS];
   logic [REM_W-1:0]     rem_s  [0:SQRT_STEPS];
   logic [ROOT_W-1:0]    root_s [0:SQRT_STEPS];
   logic                 v_s    [0:SQRT_STEPS];

   logic [RAD_PAD_W-1:0] rad_ff  [0:SQRT_STEPS-1];
   logic [RAD_PAD_W-1:0] rad_in  [0:SQRT_STEPS-1];
   logic [REM_W-1:0]     rem_ff  [0:SQRT_STEPS-1];
   logic [REM_W-1:0]     rem_in  [0:SQRT_STEPS-1];
   logic [ROOT_W-1:0]    root_ff [0:SQRT_STEPS-1];
   logic [ROOT_W-1:0]    root_in [0:SQRT_STEPS-1];
   logic                 v_ff    [0:SQRT_STEPS-1];

   logic [ROOT_W:0]  rounded;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic             vout_ff;

   assign rad_s[0]  = radicand;
   assign rem_s[0]  = '0;
   assign root_s[0] = '0;
   assign v_s[0]    = in_valid;

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_digit
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      logic             fits;

      always_comb begin
         // Bring down the next two radicand bits and try 4*root + 1.
         rem_sh     = {rem_s[j][REM_W-3:0], rad_s[j][RAD_PAD_W-1 -: 2]};
         trial      = {root_s[j], 2'b01};
         fits       = (rem_sh >= trial);
         rem_in[j]  = fits ? (rem_sh - trial) : rem_sh;
         root_in[j] = {root_s[j][ROOT_W-2:0], fits};
         rad_in[j]  = rad_s[j] << 2;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[j]  <= rad_in[j];
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en) begin
            v_ff[j] <= v_s[j];
         end
      end

      assign rad_s[j+1]  = rad_ff[j];
      assign rem_s[j+1]  = rem_ff[j];
      assign root_s[j+1] = root_ff[j];
      assign v_s[j+1]    = v_ff[j];
   end

   // A remainder above the root means the true root lies past root + 1/2.
   always_comb begin
      rounded = (ROOT_W + 1)'(root_s[SQRT_STEPS])
              + (ROOT_W + 1)'(rem_s[SQRT_STEPS] > REM_W'(root_s[SQRT_STEPS]));
      mag_in  = MAG_W'(rounded);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= mag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vout_ff <= 1'b0;
      end else if (en) begin
         vout_ff <= v_s[SQRT_STEPS];
      end
   end

   assign out_valid = vout_ff;
   assign magnitude = mag_ff;

endmodule

`default_nettype wire

/* rtl/rtp_cordic.sv */
// ----------------------------------------------------------------------
// Phase CORDIC
// CORDIC_STEPS vectoring rotations, one per stage, then clamp, round and special cases.
// ----------------------------------------------------------------------
`default_nettype none

module rtp_cordic import rtp_pkg::*; (
   input  wire logic           clock,
   input  wire logic           en,
   input  wire logic [CW-1:0]  x,
   input  wire logic [CW-1:0]  y,
   input  wire phase_case_type pcase,
   output logic [PHASE_W-1:0]  phase,
   output logic                phase_undefined
);

   // The stage count matches the square root so both results line up.
   logic signed [CW-1:0] x_s  [0:SQRT_STEPS];
   logic signed [CW-1:0] y_s  [0:SQRT_STEPS];
   logic signed [ZW-1:0] z_s  [0:SQRT_STEPS];
   phase_case_type       pc_s [0:SQRT_STEPS];

   logic signed [CW-1:0] x_ff  [0:SQRT_STEPS-1];
   logic signed [CW-1:0] x_in  [0:SQRT_STEPS-1];
   logic signed [CW-1:0] y_ff  [0:SQRT_STEPS-1];
   logic signed [CW-1:0] y_in  [0:SQRT_STEPS-1];
   logic signed [ZW-1:0] z_ff  [0:SQRT_STEPS-1];
   logic signed [ZW-1:0] z_in  [0:SQRT_STEPS-1];
   phase_case_type       pc_ff [0:SQRT_STEPS-1];

   logic [ZW-1:0]      z_clamped;
   logic [ZW-1:0]      z_rounded;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               undef_ff, undef_in;

   assign x_s[0]  = $signed(x);
   assign y_s[0]  = $signed(y);
   assign z_s[0]  = '0;
   assign pc_s[0] = pcase;

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_rot
      if (j < CORDIC_STEPS) begin : g_active
         localparam logic signed [ZW-1:0] ANG = cordic_angle(j);
         logic signed [CW-1:0] xs;
         logic signed [CW-1:0] ys;

         always_comb begin
            xs = x_s[j] >>> j;
            ys = y_s[j] >>> j;
            if (!y_s[j][CW-1]) begin
               x_in[j] = x_s[j] + ys;
               y_in[j] = y_s[j] - xs;
               z_in[j] = z_s[j] + ANG;
            end else begin
               x_in[j] = x_s[j] - ys;
               y_in[j] = y_s[j] + xs;
               z_in[j] = z_s[j] - ANG;
            end
         end
      end else begin : g_pass
         always_comb begin
            x_in[j] = x_s[j];
            y_in[j] = y_s[j];
            z_in[j] = z_s[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[j]  <= x_in[j];
            y_ff[j]  <= y_in[j];
            z_ff[j]  <= z_in[j];
            pc_ff[j] <= pc_s[j];
         end
      end

      assign x_s[j+1]  = x_ff[j];
      assign y_s[j+1]  = y_ff[j];
      assign z_s[j+1]  = z_ff[j];
      assign pc_s[j+1] = pc_ff[j];
   end

   always_comb begin
      if (z_s[SQRT_STEPS][ZW-1]) begin
         z_clamped = '0;
      end else if ($unsigned(z_s[SQRT_STEPS]) > HALF_PI_Q32) begin
         z_clamped = HALF_PI_Q32;
      end else begin
         z_clamped = $unsigned(z_s[SQRT_STEPS]);
      end
      z_rounded = z_clamped + PHASE_ROUND;

      undef_in = 1'b0;
      unique case (pc_s[SQRT_STEPS])
         PC_CORDIC:  phase_in = PHASE_W'(z_rounded >> PHASE_DROP);
         PC_ZERO:    phase_in = '0;
         PC_HALF_PI: phase_in = PHASE_HALF_PI;
         PC_UNDEF: begin
            phase_in = '0;
            undef_in = 1'b1;
         end
         default:    phase_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         phase_ff <= phase_in;
         undef_ff <= undef_in;
      end
   end

   assign phase           = phase_ff;
   assign phase_undefined = undef_ff;

endmodule

`default_nettype wire

/* rtl/rtp_out_buffer.sv */
// ----------------------------------------------------------------------
// Result buffer
// Small FIFO between the pipeline and the output channel.
// ----------------------------------------------------------------------
`default_nettype none

module rtp_out_buffer import rtp_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_valid,
   input  wire rsp_item_type push_item,
   output logic              push_ready,
   input  wire logic         pop_ready,
   output logic              head_valid,
   output rsp_item_type      head_item
);

   rsp_item_type         mem_ff [0:OUT_BUF_DEPTH-1];
   logic [BUF_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [BUF_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [BUF_CNT_W-1:0] count_ff, count_in;
   logic                 push;
   logic                 pop;

   // Ready comes from a register, so the pipeline enable is clean.
   assign push_ready = (count_ff != BUF_CNT_W'(OUT_BUF_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = head_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == BUF_PTR_W'(OUT_BUF_DEPTH - 1)) ? '0
                                                                  : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == BUF_PTR_W'(OUT_BUF_DEPTH - 1)) ? '0
                                                                  : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire
